FILE: src/xpfr_pkg.sv
// Shared types and constants of the XOR parity FEC receiver.
`default_nettype none

package xpfr_pkg;

    localparam int SEQ_W  = 31;
    localparam int WI_W   = 5;
    localparam int WORD_W = 64;

    localparam int FRAME_K_DEF       = 2;
    localparam int WINDOW_DEF        = 16;
    localparam int BLOCK_SLOTS_DEF   = 8;
    localparam int PAYLOAD_WORDS_DEF = 20;

    // Widest slot number that the slot count range allows.
    localparam int SLOT_MAX_W = 9;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PARITY,
        KIND_COPY,
        KIND_XOR
    } store_kind_t;

    typedef struct packed {
        logic              parity_flag;
        logic [SEQ_W-1:0]  seq_value;
        logic [WI_W-1:0]   word_index;
        logic [WORD_W-1:0] payload_word;
    } item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  out_seq;
        logic [WI_W-1:0]   out_word_index;
        logic [WORD_W-1:0] out_word;
        logic              out_rebuilt;
        logic              run_last;
    } result_t;

    typedef struct packed {
        store_kind_t           kind;
        logic                  fwd;
        logic                  rebuild;
        logic [SLOT_MAX_W-1:0] slot;
        logic [SEQ_W-1:0]      seq;
        logic [WI_W-1:0]       wi;
        logic [WORD_W-1:0]     word;
        logic [SEQ_W-1:0]      rseq;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/xpfr_front.sv
// Front part: classifies each beat, keeps block slots, the floor and the dedup ring.
`default_nettype none

module xpfr_front #(
    parameter int FRAME_K       = xpfr_pkg::FRAME_K_DEF,
    parameter int WINDOW        = xpfr_pkg::WINDOW_DEF,
    parameter int BLOCK_SLOTS   = xpfr_pkg::BLOCK_SLOTS_DEF,
    parameter int PAYLOAD_WORDS = xpfr_pkg::PAYLOAD_WORDS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire xpfr_pkg::item_t item,
    output logic                 cmd_push,
    input  wire logic            cmd_full,
    output xpfr_pkg::cmd_t       cmd
);
    import xpfr_pkg::*;

    localparam int KI_W   = $clog2(FRAME_K);
    localparam int CNT_W  = $clog2(FRAME_K + 1);
    localparam int SLOT_W = $clog2(BLOCK_SLOTS);
    localparam int WIN_W  = $clog2(WINDOW);
    localparam int RS_W   = SEQ_W + KI_W + 1;
    localparam int V_W    = $clog2(WINDOW * FRAME_K + 1);
    localparam int PROD_W = SEQ_W + 32;
    localparam logic [31:0] RECIP_K = 32'((64'd1 << 32) / FRAME_K);
    localparam logic [31:0] RECIP_W = 32'((64'd1 << 32) / WINDOW);
    localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / BLOCK_SLOTS);

    typedef enum logic [3:0] {
        F_IDLE, F_MUL1, F_DIV1, F_MUL2, F_DIV2, F_HEAD, F_MUL3, F_DIV3, F_WORD
    } fstate_t;

    fstate_t            state_reg;
    item_t              item_reg;
    logic [PROD_W-1:0]  prod_a_reg, prod_b_reg;
    logic [SEQ_W-1:0]   blk_reg;
    logic [KI_W-1:0]    kidx_reg;
    logic [WIN_W-1:0]   svw_reg, idw_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [31:0]        ring_reg [WINDOW];
    logic [SEQ_W-1:0]   sid_reg [BLOCK_SLOTS];
    logic               sval_reg [BLOCK_SLOTS];
    logic [FRAME_K-1:0] smask_reg [BLOCK_SLOTS];
    logic [CNT_W-1:0]   scnt_reg [BLOCK_SLOTS];
    logic               spar_reg [BLOCK_SLOTS];
    logic [SEQ_W-1:0]   high_reg, floor_reg;
    logic               act_fwd_reg, act_acc_reg;
    store_kind_t        act_kind_reg;

    logic [SEQ_W-1:0]   qa, qb;
    logic [31:0]        ra, rb;
    logic [SEQ_W-1:0]   blk_next;
    logic [KI_W-1:0]    kidx_next;
    logic [WIN_W-1:0]   svw_next;
    logic [WIN_W-1:0]   ring_addr;
    logic [31:0]        ring_rd;
    logic [SEQ_W-1:0]   cur_id;
    logic               cur_val, cur_par;
    logic [FRAME_K-1:0] cur_mask;
    logic [CNT_W-1:0]   cur_cnt;
    logic               last_word;

    logic               h_upd;
    logic [SEQ_W-1:0]   h_floor;
    logic [RS_W-1:0]    h_end;
    logic               h_fresh, h_acc, h_fwd;
    logic [FRAME_K-1:0] h_mask;
    logic [CNT_W-1:0]   h_cnt;
    logic               h_par;
    store_kind_t        h_kind;

    logic               r_found, r_ok, r_fwd;
    logic [KI_W-1:0]    r_m;
    logic [RS_W-1:0]    r_seq;
    logic [V_W-1:0]     r_v;
    logic [WIN_W-1:0]   r_idx;

    assign full      = (state_reg != F_IDLE);
    assign last_word = (32'(item_reg.word_index) == PAYLOAD_WORDS - 1);
    assign cur_id    = sid_reg[slot_reg];
    assign cur_val   = sval_reg[slot_reg];
    assign cur_par   = spar_reg[slot_reg];
    assign cur_mask  = smask_reg[slot_reg];
    assign cur_cnt   = scnt_reg[slot_reg];
    assign ring_addr = (state_reg == F_HEAD) ? svw_reg : r_idx;
    assign ring_rd   = ring_reg[ring_addr];

    // Division by constants: reciprocal product, then one correction step.
    always_comb
    begin
        qa = prod_a_reg[PROD_W-1:32];
        qb = prod_b_reg[PROD_W-1:32];
        ra = {1'b0, item_reg.seq_value} - 32'(qa) * 32'(FRAME_K);
        rb = {1'b0, item_reg.seq_value} - 32'(qb) * 32'(WINDOW);
        if (ra >= 32'(FRAME_K))
        begin
            qa = qa + 1'b1;
            ra = ra - 32'(FRAME_K);
        end
        if (rb >= 32'(WINDOW))
        begin
            rb = rb - 32'(WINDOW);
        end
        blk_next  = item_reg.parity_flag ? item_reg.seq_value : qa;
        kidx_next = ra[KI_W-1:0];
        svw_next  = rb[WIN_W-1:0];
    end

    logic [31:0] rs, rw;
    always_comb
    begin
        rs = {1'b0, blk_reg} - 32'(prod_a_reg[PROD_W-1:32]) * 32'(BLOCK_SLOTS);
        if (rs >= 32'(BLOCK_SLOTS))
        begin
            rs = rs - 32'(BLOCK_SLOTS);
        end
        rw = {1'b0, cur_id} - 32'(prod_a_reg[PROD_W-1:32]) * 32'(WINDOW);
        if (rw >= 32'(WINDOW))
        begin
            rw = rw - 32'(WINDOW);
        end
    end

    // Packet start decision.
    always_comb
    begin
        h_upd   = !item_reg.parity_flag && (item_reg.seq_value > high_reg);
        h_floor = floor_reg;
        if (h_upd)
        begin
            h_floor = ({1'b0, item_reg.seq_value} > 32'(WINDOW)) ?
                      SEQ_W'({1'b0, item_reg.seq_value} - 32'(WINDOW)) : '0;
        end
        h_end   = RS_W'(blk_reg) * RS_W'(FRAME_K) + RS_W'(FRAME_K - 1);
        h_fresh = !cur_val || (cur_id < blk_reg);
        h_acc   = !(h_end < RS_W'(h_floor)) && (h_fresh || !(cur_id > blk_reg));
        h_mask  = h_fresh ? '0 : cur_mask;
        h_cnt   = h_fresh ? '0 : cur_cnt;
        h_par   = h_fresh ? 1'b0 : cur_par;
        h_kind  = KIND_NONE;
        h_fwd   = 1'b0;
        if (item_reg.parity_flag)
        begin
            if (!h_par)
            begin
                h_kind = KIND_PARITY;
            end
            h_par = 1'b1;
        end
        else
        begin
            h_fwd = (item_reg.seq_value >= h_floor) && (ring_rd != {1'b0, item_reg.seq_value});
            if (!h_mask[kidx_reg])
            begin
                h_mask[kidx_reg] = 1'b1;
                h_cnt  = h_cnt + 1'b1;
                h_kind = (h_cnt == CNT_W'(1)) ? KIND_COPY : KIND_XOR;
            end
        end
    end

    // Reconstruction check at the end of a packet.
    always_comb
    begin
        r_found = 1'b0;
        r_m     = '0;
        for (int i = FRAME_K - 1; i >= 0; i--)
        begin
            if (!cur_mask[i])
            begin
                r_found = 1'b1;
                r_m     = KI_W'(i);
            end
        end
        r_ok  = cur_par && (cur_cnt == CNT_W'(FRAME_K - 1)) && r_found;
        r_seq = RS_W'(cur_id) * RS_W'(FRAME_K) + RS_W'(r_m);
        r_v   = V_W'(idw_reg) * V_W'(FRAME_K) + V_W'(r_m);
        for (int i = 0; i < FRAME_K; i++)
        begin
            if (r_v >= V_W'(WINDOW))
            begin
                r_v = r_v - V_W'(WINDOW);
            end
        end
        r_idx = r_v[WIN_W-1:0];
        r_fwd = !(r_seq < RS_W'(floor_reg)) && (RS_W'(ring_rd) != r_seq);
    end

    always_comb
    begin
        cmd_push     = (state_reg == F_WORD) && act_acc_reg && !cmd_full;
        cmd.kind     = act_kind_reg;
        cmd.fwd      = act_fwd_reg;
        cmd.rebuild  = last_word && r_ok && r_fwd;
        cmd.slot     = SLOT_MAX_W'(slot_reg);
        cmd.seq      = item_reg.seq_value;
        cmd.wi       = item_reg.word_index;
        cmd.word     = item_reg.payload_word;
        cmd.rseq     = r_seq[SEQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            high_reg     <= '0;
            floor_reg    <= '0;
            act_fwd_reg  <= 1'b0;
            act_acc_reg  <= 1'b0;
            act_kind_reg <= KIND_NONE;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '1;
            end
            for (int i = 0; i < BLOCK_SLOTS; i++)
            begin
                sid_reg[i]   <= '0;
                sval_reg[i]  <= 1'b0;
                smask_reg[i] <= '0;
                scnt_reg[i]  <= '0;
                spar_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        item_reg <= item;
                        if ((32'(item.word_index) < PAYLOAD_WORDS) &&
                            ((item.word_index == '0) || act_acc_reg))
                        begin
                            state_reg <= F_MUL1;
                        end
                        else if (32'(item.word_index) == PAYLOAD_WORDS - 1)
                        begin
                            act_acc_reg <= 1'b0;
                        end
                    end
                end
                F_MUL1:
                begin
                    prod_a_reg <= PROD_W'(item_reg.seq_value) * PROD_W'(RECIP_K);
                    prod_b_reg <= PROD_W'(item_reg.seq_value) * PROD_W'(RECIP_W);
                    state_reg  <= F_DIV1;
                end
                F_DIV1:
                begin
                    blk_reg   <= blk_next;
                    kidx_reg  <= kidx_next;
                    svw_reg   <= svw_next;
                    state_reg <= F_MUL2;
                end
                F_MUL2:
                begin
                    prod_a_reg <= PROD_W'(blk_reg) * PROD_W'(RECIP_S);
                    state_reg  <= F_DIV2;
                end
                F_DIV2:
                begin
                    slot_reg  <= rs[SLOT_W-1:0];
                    state_reg <= F_HEAD;
                end
                F_HEAD:
                begin
                    if (item_reg.word_index == '0)
                    begin
                        if (h_upd)
                        begin
                            high_reg <= item_reg.seq_value;
                        end
                        floor_reg    <= h_floor;
                        act_acc_reg  <= h_acc;
                        act_fwd_reg  <= h_acc && h_fwd;
                        act_kind_reg <= h_acc ? h_kind : KIND_NONE;
                        if (h_acc)
                        begin
                            sval_reg[slot_reg]  <= 1'b1;
                            sid_reg[slot_reg]   <= h_fresh ? blk_reg : cur_id;
                            smask_reg[slot_reg] <= h_mask;
                            scnt_reg[slot_reg]  <= h_cnt;
                            spar_reg[slot_reg]  <= h_par;
                            if (h_fwd && !item_reg.parity_flag)
                            begin
                                ring_reg[svw_reg] <= {1'b0, item_reg.seq_value};
                            end
                        end
                    end
                    state_reg <= last_word ? F_MUL3 : F_WORD;
                end
                F_MUL3:
                begin
                    prod_a_reg <= PROD_W'(cur_id) * PROD_W'(RECIP_W);
                    state_reg  <= F_DIV3;
                end
                F_DIV3:
                begin
                    idw_reg   <= rw[WIN_W-1:0];
                    state_reg <= F_WORD;
                end
                F_WORD:
                begin
                    if (!act_acc_reg || !cmd_full)
                    begin
                        if (act_acc_reg && last_word && r_ok)
                        begin
                            smask_reg[slot_reg][r_m] <= 1'b1;
                            scnt_reg[slot_reg]       <= CNT_W'(FRAME_K);
                            if (r_fwd)
                            begin
                                ring_reg[r_idx] <= r_seq[31:0];
                            end
                        end
                        if (last_word)
                        begin
                            act_acc_reg  <= 1'b0;
                            act_fwd_reg  <= 1'b0;
                            act_kind_reg <= KIND_NONE;
                        end
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/xpfr_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
`default_nettype none

module xpfr_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire xpfr_pkg::cmd_t din,
    input  wire logic           pop,
    output logic                empty,
    output xpfr_pkg::cmd_t      dout
);
    import xpfr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

FILE: src/xpfr_back.sv
// Back part: word stores, forwarding and rebuilding of missing frames.
`default_nettype none

module xpfr_back #(
    parameter int BLOCK_SLOTS   = xpfr_pkg::BLOCK_SLOTS_DEF,
    parameter int PAYLOAD_WORDS = xpfr_pkg::PAYLOAD_WORDS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    input  wire xpfr_pkg::cmd_t cmd,
    input  wire logic           pop,
    output logic                empty,
    output xpfr_pkg::result_t   result
);
    import xpfr_pkg::*;

    localparam int SLOT_W = $clog2(BLOCK_SLOTS);
    localparam int DEPTH  = BLOCK_SLOTS * PAYLOAD_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(PAYLOAD_WORDS + 1);

    typedef enum logic [2:0] {
        B_IDLE, B_RD, B_WR, B_EMIT, B_RRD, B_REMIT
    } bstate_t;

    bstate_t            state_reg;
    cmd_t               cmd_reg;
    logic [K_W-1:0]     k_reg;
    logic [WORD_W-1:0]  xrd_reg, prd_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic [WORD_W-1:0]  xor_mem [DEPTH];
    logic [WORD_W-1:0]  par_mem [DEPTH];

    logic [ADDR_W-1:0]  base, wr_addr, rd_addr;
    logic               out_free, k_last, emit_go;

    assign base     = ADDR_W'(cmd_reg.slot[SLOT_W-1:0]) * ADDR_W'(PAYLOAD_WORDS);
    assign wr_addr  = base + ADDR_W'(cmd_reg.wi);
    assign rd_addr  = (state_reg == B_RD) ? wr_addr : base + ADDR_W'(k_reg);
    assign out_free = !out_valid_reg || pop;
    assign emit_go  = out_free && (state_reg == B_EMIT || state_reg == B_REMIT);
    assign k_last   = (32'(k_reg) == PAYLOAD_WORDS - 1);
    assign cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == B_RD || state_reg == B_RRD)
        begin
            xrd_reg <= xor_mem[rd_addr];
            prd_reg <= par_mem[rd_addr];
        end
        if (state_reg == B_WR)
        begin
            case (cmd_reg.kind)
                KIND_PARITY: par_mem[wr_addr] <= cmd_reg.word;
                KIND_COPY:   xor_mem[wr_addr] <= cmd_reg.word;
                KIND_XOR:    xor_mem[wr_addr] <= xrd_reg ^ cmd_reg.word;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if (pop && out_valid_reg && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= B_RD;
                    end
                end
                B_RD:
                begin
                    state_reg <= B_WR;
                end
                B_WR:
                begin
                    k_reg <= '0;
                    if (cmd_reg.fwd)
                    begin
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        state_reg <= cmd_reg.rebuild ? B_RRD : B_IDLE;
                    end
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.out_seq        <= cmd_reg.seq;
                        out_reg.out_word_index <= cmd_reg.wi;
                        out_reg.out_word       <= cmd_reg.word;
                        out_reg.out_rebuilt    <= 1'b0;
                        out_reg.run_last       <= !cmd_reg.rebuild;
                        state_reg              <= cmd_reg.rebuild ? B_RRD : B_IDLE;
                    end
                end
                B_RRD:
                begin
                    state_reg <= B_REMIT;
                end
                B_REMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.out_seq        <= cmd_reg.rseq;
                        out_reg.out_word_index <= WI_W'(k_reg);
                        out_reg.out_word       <= xrd_reg ^ prd_reg;
                        out_reg.out_rebuilt    <= 1'b1;
                        out_reg.run_last       <= k_last;
                        k_reg                  <= k_reg + 1'b1;
                        state_reg              <= k_last ? B_IDLE : B_RRD;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/xor_parity_fec_receiver_top.sv
// Top level of the XOR parity FEC receiver.
//
// Channel   Ports                  Beat
// item      push, full, item       one payload word with its packet header
// result    empty, pop, result     one forwarded or rebuilt payload word
//
// The front part works through reciprocal divisions for each word of an open packet, with an
// extra division on the last word, and takes no new word until done; other words are dropped.
// The back part reads and then writes each stored word, emitting it if it is forwarded, and reads
// then emits each rebuilt word, set by the single read port of the word stores.
// Reset clears slots, floor and dedup ring at once; the word stores need no clearing.
// Either side may stall; a two-entry command queue lets the front run ahead of the back.
`default_nettype none

module xor_parity_fec_receiver_top #(
    parameter int FRAME_K       = xpfr_pkg::FRAME_K_DEF,
    parameter int WINDOW        = xpfr_pkg::WINDOW_DEF,
    parameter int BLOCK_SLOTS   = xpfr_pkg::BLOCK_SLOTS_DEF,
    parameter int PAYLOAD_WORDS = xpfr_pkg::PAYLOAD_WORDS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire xpfr_pkg::item_t item,
    output logic                 empty,
    input  wire logic            pop,
    output xpfr_pkg::result_t    result
);
    import xpfr_pkg::*;

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_in, cmd_out;

    xpfr_front #(
        .FRAME_K       (FRAME_K),
        .WINDOW        (WINDOW),
        .BLOCK_SLOTS   (BLOCK_SLOTS),
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (cmd_in)
    );

    xpfr_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_out)
    );

    xpfr_back #(
        .BLOCK_SLOTS   (BLOCK_SLOTS),
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    a_rebuilt_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_rebuilt) |-> (32'(result.out_word_index) < PAYLOAD_WORDS))
        else $error("rebuilt word index beyond the frame");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the XOR parity FEC receiver with predictor, driver and monitor.
module tb;
    import xpfr_pkg::*;

    localparam int K      = 2;
    localparam int WIN    = 16;
    localparam int SLOTS  = 8;
    localparam int PW     = 20;
    localparam int DEPTH  = SLOTS * PW;
    localparam int TARGET = 350;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    item_t   item = '0;
    logic    full;
    logic    empty;
    result_t result;

    xor_parity_fec_receiver_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver state mirror.
    logic [31:0]  ring [WIN];
    logic [30:0]  blk_id [SLOTS];
    bit           blk_used [SLOTS];
    bit [1:0]     got_mask [SLOTS];
    int           got_cnt [SLOTS];
    bit           par_got [SLOTS];
    logic [63:0]  xor_mem [DEPTH];
    logic [63:0]  par_mem [DEPTH];
    bit           xor_wr [DEPTH];
    bit           par_wr [DEPTH];
    logic [31:0]  top_seq;
    logic [31:0]  low_mark;
    bit           pk_fwd;
    bit           pk_acc;
    store_kind_t  pk_kind;

    logic [31:0]  s_ring [WIN];
    logic [30:0]  s_blk_id [SLOTS];
    bit           s_blk_used [SLOTS];
    bit [1:0]     s_got_mask [SLOTS];
    int           s_got_cnt [SLOTS];
    bit           s_par_got [SLOTS];
    logic [63:0]  s_xor_mem [DEPTH];
    logic [63:0]  s_par_mem [DEPTH];
    bit           s_xor_wr [DEPTH];
    bit           s_par_wr [DEPTH];
    logic [31:0]  s_top_seq;
    logic [31:0]  s_low_mark;
    bit           s_pk_fwd;
    bit           s_pk_acc;
    store_kind_t  s_pk_kind;
    int           s_nstim;
    int           s_nexp;

    bit           unsafe;
    item_t        stim_q [$];
    result_t      frames_q [$];
    int           rebuilt_words;

    int  sent_idx = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_left = 0;
    int  got = 0;
    int  fails = 0;
    bit  stalled_once = 0;
    bit  quiet = 0;

    function automatic bit seen_check(logic [63:0] s);
        int i;
        if (s < {32'd0, low_mark})
            return 1'b0;
        i = int'(s % WIN);
        if ({32'd0, ring[i]} == s)
            return 1'b0;
        ring[i] = s[31:0];
        return 1'b1;
    endfunction

    task automatic open_packet(bit ip, logic [30:0] sv);
        logic [31:0] blk;
        int          slot;
        int          idx;
        pk_fwd  = 0;
        pk_acc  = 0;
        pk_kind = KIND_NONE;
        if (!ip && {1'b0, sv} > top_seq)
        begin
            top_seq  = {1'b0, sv};
            low_mark = (top_seq > WIN) ? top_seq - WIN : 32'd0;
        end
        blk = ip ? {1'b0, sv} : {1'b0, sv} / K;
        if ({32'd0, blk} * K + (K - 1) < {32'd0, low_mark})
            return;
        slot = int'(blk % SLOTS);
        if (!blk_used[slot] || {1'b0, blk_id[slot]} < blk)
        begin
            blk_used[slot] = 1;
            blk_id[slot]   = blk[30:0];
            got_mask[slot] = 0;
            got_cnt[slot]  = 0;
            par_got[slot]  = 0;
            for (int k = 0; k < PW; k++)
            begin
                xor_wr[slot * PW + k] = 0;
                par_wr[slot * PW + k] = 0;
            end
        end
        else if ({1'b0, blk_id[slot]} > blk)
            return;
        pk_acc = 1;
        if (ip)
        begin
            if (!par_got[slot])
            begin
                par_got[slot] = 1;
                pk_kind = KIND_PARITY;
            end
        end
        else
        begin
            pk_fwd = seen_check({33'd0, sv});
            idx = int'(sv % K);
            if (!got_mask[slot][idx])
            begin
                got_mask[slot][idx] = 1;
                got_cnt[slot]++;
                pk_kind = (got_cnt[slot] == 1) ? KIND_COPY : KIND_XOR;
            end
        end
    endtask

    task automatic try_rebuild(int slot, inout int n);
        int          m;
        int          a;
        logic [63:0] rseq;
        result_t     r;
        if (!par_got[slot] || got_cnt[slot] != K - 1)
            return;
        m = 0;
        while (m < K && got_mask[slot][m])
            m++;
        if (m >= K)
            return;
        rseq = {33'd0, blk_id[slot]} * K + m;
        if (seen_check(rseq))
        begin
            for (int k = 0; k < PW; k++)
            begin
                a = slot * PW + k;
                if (!xor_wr[a] || !par_wr[a])
                    unsafe = 1;
                r.out_seq        = rseq[30:0];
                r.out_word_index = k[4:0];
                r.out_word       = xor_mem[a] ^ par_mem[a];
                r.out_rebuilt    = 1;
                r.run_last       = 0;
                frames_q.push_back(r);
                n++;
            end
        end
        got_mask[slot][m] = 1;
        got_cnt[slot]     = K;
    endtask

    task automatic add_beat(item_t it);
        int          n;
        int          slot;
        int          a;
        logic [31:0] blk;
        result_t     r;
        n = 0;
        stim_q.push_back(it);
        if (it.word_index == 0)
            open_packet(it.parity_flag, it.seq_value);
        if (it.word_index < PW)
        begin
            if (pk_acc)
            begin
                blk  = it.parity_flag ? {1'b0, it.seq_value} : {1'b0, it.seq_value} / K;
                slot = int'(blk % SLOTS);
                a    = slot * PW + int'(it.word_index);
                case (pk_kind)
                    KIND_PARITY:
                    begin
                        par_mem[a] = it.payload_word;
                        par_wr[a]  = 1;
                    end
                    KIND_COPY:
                    begin
                        xor_mem[a] = it.payload_word;
                        xor_wr[a]  = 1;
                    end
                    KIND_XOR:
                    begin
                        if (!xor_wr[a])
                            unsafe = 1;
                        xor_mem[a] = xor_mem[a] ^ it.payload_word;
                    end
                    default: ;
                endcase
                if (pk_fwd)
                begin
                    r.out_seq        = it.seq_value;
                    r.out_word_index = it.word_index;
                    r.out_word       = it.payload_word;
                    r.out_rebuilt    = 0;
                    r.run_last       = 0;
                    frames_q.push_back(r);
                    n++;
                end
                if (it.word_index == PW - 1)
                    try_rebuild(slot, n);
            end
            if (it.word_index == PW - 1)
            begin
                pk_acc  = 0;
                pk_fwd  = 0;
                pk_kind = KIND_NONE;
            end
        end
        if (n > 0)
        begin
            r = frames_q.pop_back();
            r.run_last = 1;
            frames_q.push_back(r);
        end
    endtask

    task automatic snapshot();
        s_ring = ring; s_blk_id = blk_id; s_blk_used = blk_used; s_got_mask = got_mask;
        s_got_cnt = got_cnt; s_par_got = par_got; s_xor_mem = xor_mem; s_par_mem = par_mem;
        s_xor_wr = xor_wr; s_par_wr = par_wr; s_top_seq = top_seq; s_low_mark = low_mark;
        s_pk_fwd = pk_fwd; s_pk_acc = pk_acc; s_pk_kind = pk_kind;
        s_nstim = stim_q.size(); s_nexp = frames_q.size();
    endtask

    task automatic rollback();
        ring = s_ring; blk_id = s_blk_id; blk_used = s_blk_used; got_mask = s_got_mask;
        got_cnt = s_got_cnt; par_got = s_par_got; xor_mem = s_xor_mem; par_mem = s_par_mem;
        xor_wr = s_xor_wr; par_wr = s_par_wr; top_seq = s_top_seq; low_mark = s_low_mark;
        pk_fwd = s_pk_fwd; pk_acc = s_pk_acc; pk_kind = s_pk_kind;
        while (stim_q.size() > s_nstim)
            void'(stim_q.pop_back());
        while (frames_q.size() > s_nexp)
            void'(frames_q.pop_back());
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom % 8)
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic gen_packet(bit ip, logic [30:0] sv, bit noisy);
        item_t it;
        if (noisy && $urandom % 3 == 0)
        begin
            it = '{parity_flag: ip, seq_value: sv, word_index: 5'($urandom_range(1, PW - 1)),
                   payload_word: rand_word()};
            add_beat(it);
        end
        for (int wi = 0; wi < PW; wi++)
        begin
            if (noisy && $urandom % 10 == 0)
            begin
                it = '{parity_flag: 1'($urandom), seq_value: 31'($urandom),
                       word_index: 5'($urandom_range(PW, 31)), payload_word: rand_word()};
                add_beat(it);
            end
            it.parity_flag  = ip;
            it.seq_value    = sv;
            it.word_index   = wi[4:0];
            it.payload_word = rand_word();
            if (noisy && $urandom % 12 == 0)
            begin
                it.parity_flag = 1'($urandom);
                it.seq_value   = sv + 31'($urandom_range(0, 3));
            end
            add_beat(it);
            if (noisy && wi > 0 && $urandom % 15 == 0)
                break;
        end
    endtask

    task automatic send_packet(bit ip, logic [30:0] sv);
        bit noisy;
        noisy = ($urandom % 4 == 0);
        snapshot();
        unsafe = 0;
        gen_packet(ip, sv, noisy);
        if (unsafe && noisy)
        begin
            rollback();
            unsafe = 0;
            gen_packet(ip, sv, 0);
        end
        if (unsafe)
            rollback();
    endtask

    task automatic send_block(logic [30:0] b);
        int mode;
        int miss;
        int first;
        mode  = $urandom % 4;
        miss  = $urandom % K;
        first = $urandom % K;
        if (mode == 2)
            send_packet(1, b);
        for (int j = 0; j < K; j++)
        begin
            int m;
            m = (first + j) % K;
            if (mode == 0 || mode == 3 || m != miss)
                send_packet(0, 31'(b * K + m));
        end
        if (mode == 1 || mode == 3)
            send_packet(1, b);
        if ($urandom % 5 == 0)
            send_packet(0, 31'(b * K + first));
    endtask

    task automatic build_stimulus();
        item_t       it;
        logic [30:0] base;
        logic [30:0] b;
        int          nblk;
        for (int s = 0; s < WIN; s++)
            ring[s] = '1;
        for (int s = 0; s < SLOTS; s++)
        begin
            blk_id[s] = 0; blk_used[s] = 0; got_mask[s] = 0; got_cnt[s] = 0; par_got[s] = 0;
        end
        for (int a = 0; a < DEPTH; a++)
        begin
            xor_mem[a] = 0; par_mem[a] = 0; xor_wr[a] = 0; par_wr[a] = 0;
        end
        top_seq = 0; low_mark = 0; pk_fwd = 0; pk_acc = 0; pk_kind = KIND_NONE;

        it = '{parity_flag: 0, seq_value: 5, word_index: 7, payload_word: '1};
        add_beat(it);
        it = '{parity_flag: 1, seq_value: '1, word_index: 20, payload_word: '1};
        add_beat(it);
        it = '{parity_flag: 0, seq_value: 0, word_index: 31, payload_word: '0};
        add_beat(it);
        for (int wi = 0; wi < 3; wi++)
        begin
            it = '{parity_flag: 0, seq_value: 0, word_index: wi[4:0], payload_word: rand_word()};
            add_beat(it);
        end
        send_packet(0, 0);
        send_packet(1, 0);

        base = 1;
        nblk = 0;
        while (stim_q.size() < TARGET)
        begin
            b = base + 31'($urandom_range(0, 2));
            if (base > 12 && $urandom % 6 == 0)
                b = base - 31'($urandom_range(3, 12));
            if (b > 31'h3FFFFFFF)
                b = 31'h3FFFFFFF;
            send_block(b);
            base++;
            nblk++;
            if (nblk == 6)
                base = 31'($urandom % 32'h3FFFFF00);
            if (nblk == 12)
                base = 31'h3FFFFFF8;
        end
        send_packet(0, 31'h7FFFFFFF);
        send_packet(1, 31'h3FFFFFFF);
        send_packet(1, 31'h7FFFFFFF);
        foreach (frames_q[i])
            if (frames_q[i].out_rebuilt)
                rebuilt_words++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && (!push || !full))
        begin
            if (push)
                sent_idx++;
            quiet = (sent_idx > stim_q.size() - 60);
            if (in_gap > 0)
            begin
                in_gap--;
                push <= 1'b0;
            end
            else if (sent_idx < stim_q.size())
            begin
                push <= 1'b1;
                item <= stim_q[sent_idx];
                if (!quiet && $urandom % 8 == 0)
                    in_gap = $urandom_range(1, 4);
            end
            else
                push <= 1'b0;
        end
    end

    // Long hold-off of the result side, counted on its own.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!stalled_once && got >= 40)
            begin
                stalled_once = 1;
                hold_left = 400;
            end
            else if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                result_t want;
                got++;
                if (frames_q.size() == 0)
                begin
                    $error("result beat with no expected beat: %p", result);
                    fails++;
                end
                else
                begin
                    want = frames_q.pop_front();
                    if (result.out_seq !== want.out_seq)
                    begin
                        $error("out_seq expected %h actual %h", want.out_seq, result.out_seq);
                        fails++;
                    end
                    if (result.out_word_index !== want.out_word_index)
                    begin
                        $error("out_word_index expected %0d actual %0d",
                               want.out_word_index, result.out_word_index);
                        fails++;
                    end
                    if (result.out_word !== want.out_word)
                    begin
                        $error("out_word expected %h actual %h", want.out_word, result.out_word);
                        fails++;
                    end
                    if (result.out_rebuilt !== want.out_rebuilt)
                    begin
                        $error("out_rebuilt expected %b actual %b",
                               want.out_rebuilt, result.out_rebuilt);
                        fails++;
                    end
                    if (result.run_last !== want.run_last)
                    begin
                        $error("run_last expected %b actual %b", want.run_last, result.run_last);
                        fails++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                pop <= 1'b0;
            end
            else if (hold_left > 0)
                pop <= 1'b0;
            else
            begin
                pop <= 1'b1;
                if (!quiet && $urandom % 7 == 0)
                    out_gap = $urandom_range(1, 4);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Timeout after %0d result beats", got);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rebuilt_words = 0;
        build_stimulus();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (sent_idx == stim_q.size());
        wait (frames_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("Sent %0d item beats; checked %0d result beats, %0d of them rebuilt.",
                 stim_q.size(), got, rebuilt_words);
        if (fails == 0 && frames_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: xor_parity_fec_receiver_top.f
src/xpfr_pkg.sv
src/xpfr_front.sv
src/xpfr_cmd_fifo.sv
src/xpfr_back.sv
src/xor_parity_fec_receiver_top.sv
tb/tb.sv
